[rtl/sbrs_pkg.sv]
package sbrs_pkg;

    // Stage codes
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_BEGIN    = 4'd1;
    localparam logic [3:0] ST_OUTPUT   = 4'd2;
    localparam logic [3:0] ST_DYNMODEL = 4'd3;
    localparam logic [3:0] ST_NAVFREQ  = 4'd4;
    localparam logic [3:0] ST_NAVRATE  = 4'd5;
    localparam logic [3:0] ST_AUTOPVT  = 4'd6;
    localparam logic [3:0] ST_DONE     = 4'd7;
    localparam logic [3:0] ST_QUAR     = 4'd8;
    localparam logic [3:0] ST_FAILED   = 4'd9;

    // Status codes
    localparam logic [2:0] RS_OK     = 3'd0;
    localparam logic [2:0] RS_INIT   = 3'd1;
    localparam logic [2:0] RS_CONFIG = 3'd2;
    localparam logic [2:0] RS_RATE   = 3'd3;
    localparam logic [2:0] RS_BUS    = 3'd4;

    // Event codes
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_ARM     = 3'd1;
    localparam logic [2:0] MODE_FAIL    = 3'd2;
    localparam logic [2:0] MODE_CONFIRM = 3'd3;
    localparam logic [2:0] MODE_QUAR    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_FAST_LIMIT    = 2'd0;
    localparam logic [1:0] REG_FAST_INTERVAL = 2'd1;
    localparam logic [1:0] REG_SLOW_INTERVAL = 2'd2;
    localparam logic [1:0] REG_SKIP_OUTPUT   = 2'd3;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  fail_reason;
        logic        exchange_ok;
        logic        buffer_ready;
        logic        bus_ready;
        logic [31:0] now_ms;
        logic [2:0]  mode;
    } event_t;

    typedef struct packed {
        logic [15:0] failure_count;
        logic [2:0]  last_status;
        logic [3:0]  failed_stage;
        logic [3:0]  stage_now;
    } report_t;

endpackage

[rtl/staged_bringup_retry_sequencer.sv]
// Bring-up retry sequencer. Each request on the s_axis side is one event (tick, arm, external
// fail, confirm streaming, quarantine) and yields exactly one report on the m_axis side with the
// stage, last failed stage, status and saturating failure count after the event. Events are
// taken one per clock cycle while reports are drained. A request lands in the input register
// when it is accepted, and the state update then loads the report register, from which the
// report is taken. The state registers update once per event; a stalled report holds the
// input once the input register is full. Backoff expiry uses a wrapped signed compare of
// now_ms against the stored retry time. Configuration writes are taken at any time on the
// cfg channel but must only be issued while no event is in flight.
module staged_bringup_retry_sequencer (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] now_ms, [32] bus_ready, [33] buffer_ready, [34] exchange_ok,
    // [37:35] fail_reason, [39:38] zero
    input  logic [39:0] s_axis_tdata,
    // [2:0] mode
    input  logic [2:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] stage_now, [7:4] failed_stage, [10:8] last_status, [26:11] failure_count,
    // [31:27] zero
    output logic [31:0] m_axis_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import sbrs_pkg::*;

    logic [7:0]  fast_limit_reg;
    logic [15:0] fast_interval_reg;
    logic [31:0] slow_interval_reg;
    logic        skip_output_reg;

    logic        in_valid_reg;
    event_t      item_reg;
    logic        out_valid_reg;
    report_t     report_reg;

    logic [3:0]  stage_reg, stage_next;
    logic [3:0]  failed_stage_reg, failed_stage_next;
    logic [2:0]  status_reg, status_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] retry_time_reg, retry_time_next;

    logic        advance;
    logic        arm_req;
    logic        fail_req;
    logic [2:0]  fail_why;
    logic [31:0] wait_diff;
    logic [15:0] count_inc;
    logic        use_fast;
    logic [31:0] backoff;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_limit_reg    <= 8'd5;
            fast_interval_reg <= 16'd250;
            slow_interval_reg <= 32'd5000;
            skip_output_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FAST_LIMIT:    fast_limit_reg    <= cfg_data[7:0];
                REG_FAST_INTERVAL: fast_interval_reg <= cfg_data[15:0];
                REG_SLOW_INTERVAL: slow_interval_reg <= cfg_data;
                REG_SKIP_OUTPUT:   skip_output_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.mode         <= s_axis_tuser;
            item_reg.now_ms       <= s_axis_tdata[31:0];
            item_reg.bus_ready    <= s_axis_tdata[32];
            item_reg.buffer_ready <= s_axis_tdata[33];
            item_reg.exchange_ok  <= s_axis_tdata[34];
            item_reg.fail_reason  <= s_axis_tdata[37:35];
        end
    end

    // Failure bookkeeping shared by tick and external fail
    assign wait_diff = item_reg.now_ms - retry_time_reg;
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;
    assign use_fast  = count_inc <= {8'd0, fast_limit_reg};
    assign backoff   = use_fast ? {16'd0, fast_interval_reg} : slow_interval_reg;

    always_comb
    begin
        stage_next        = stage_reg;
        failed_stage_next = failed_stage_reg;
        status_next       = status_reg;
        count_next        = count_reg;
        retry_time_next   = retry_time_reg;
        arm_req           = 1'b0;
        fail_req          = 1'b0;
        fail_why          = RS_OK;

        case (item_reg.mode)
            MODE_TICK:
            begin
                case (stage_reg)
                    ST_IDLE, ST_FAILED:
                        arm_req = !wait_diff[31];
                    ST_BEGIN, ST_OUTPUT, ST_DYNMODEL, ST_NAVFREQ, ST_NAVRATE, ST_AUTOPVT:
                    begin
                        if (!item_reg.bus_ready)
                        begin
                            fail_req = 1'b1;
                            fail_why = RS_BUS;
                        end
                        else
                        begin
                            case (stage_reg)
                                ST_BEGIN:
                                begin
                                    if (!item_reg.buffer_ready || !item_reg.exchange_ok)
                                    begin
                                        fail_req = 1'b1;
                                        fail_why = RS_INIT;
                                    end
                                    else
                                        stage_next = skip_output_reg ? ST_DYNMODEL : ST_OUTPUT;
                                end
                                ST_OUTPUT:
                                begin
                                    fail_req   = !item_reg.exchange_ok;
                                    fail_why   = RS_CONFIG;
                                    stage_next = ST_DYNMODEL;
                                end
                                ST_DYNMODEL:
                                begin
                                    fail_req   = !item_reg.exchange_ok;
                                    fail_why   = RS_CONFIG;
                                    stage_next = ST_NAVFREQ;
                                end
                                ST_NAVFREQ:
                                begin
                                    fail_req   = !item_reg.exchange_ok;
                                    fail_why   = RS_RATE;
                                    stage_next = ST_NAVRATE;
                                end
                                ST_NAVRATE:
                                begin
                                    fail_req   = !item_reg.exchange_ok;
                                    fail_why   = RS_CONFIG;
                                    stage_next = ST_AUTOPVT;
                                end
                                default:
                                begin
                                    fail_req    = !item_reg.exchange_ok;
                                    fail_why    = RS_CONFIG;
                                    stage_next  = ST_DONE;
                                    status_next = RS_OK;
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            MODE_ARM:
                arm_req = 1'b1;
            MODE_FAIL:
            begin
                fail_req = 1'b1;
                fail_why = (item_reg.fail_reason inside {[3'd5:3'd7]}) ? RS_BUS
                                                                      : item_reg.fail_reason;
            end
            MODE_CONFIRM:
                count_next = 16'd0;
            MODE_QUAR:
            begin
                stage_next        = ST_QUAR;
                failed_stage_next = ST_BEGIN;
                status_next       = RS_BUS;
            end
            default: ;
        endcase

        // Quarantine blocks arming and failing; a failure overrides any stage advance
        if (arm_req && stage_reg != ST_QUAR)
        begin
            stage_next      = ST_BEGIN;
            status_next     = RS_OK;
            retry_time_next = item_reg.now_ms;
        end
        if (fail_req && stage_reg != ST_QUAR)
        begin
            if (stage_reg != ST_FAILED)
                failed_stage_next = stage_reg;
            stage_next      = ST_FAILED;
            status_next     = fail_why;
            count_next      = count_inc;
            retry_time_next = item_reg.now_ms + backoff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg        <= ST_IDLE;
            failed_stage_reg <= ST_IDLE;
            status_reg       <= RS_OK;
            count_reg        <= 16'd0;
            retry_time_reg   <= 32'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                stage_reg        <= stage_next;
                failed_stage_reg <= failed_stage_next;
                status_reg       <= status_next;
                count_reg        <= count_next;
                retry_time_reg   <= retry_time_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            report_reg.stage_now     <= stage_next;
            report_reg.failed_stage  <= failed_stage_next;
            report_reg.last_status   <= status_next;
            report_reg.failure_count <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, report_reg};

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

import sbrs_pkg::*;

class bringup_scoreboard;
    logic [7:0]  fast_limit;
    logic [15:0] fast_interval_ms;
    logic [31:0] slow_interval_ms;
    logic        skip_output;

    logic [3:0]  stage;
    logic [3:0]  failed_at;
    logic [2:0]  status;
    logic [15:0] failures;
    logic [31:0] retry_at_ms;

    report_t     expected_reports[$];
    int          mismatches;
    int          reports_checked;

    function new();
        fast_limit       = 8'd5;
        fast_interval_ms = 16'd250;
        slow_interval_ms = 32'd5000;
        skip_output      = 1'b0;
        stage            = ST_IDLE;
        failed_at        = ST_IDLE;
        status           = RS_OK;
        failures         = '0;
        retry_at_ms      = '0;
        mismatches       = 0;
        reports_checked  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            REG_FAST_LIMIT:    fast_limit       = data[7:0];
            REG_FAST_INTERVAL: fast_interval_ms = data[15:0];
            REG_SLOW_INTERVAL: slow_interval_ms = data;
            REG_SKIP_OUTPUT:   skip_output      = data[0];
            default: ;
        endcase
    endfunction

    function void arm_at(logic [31:0] now_ms);
        if (stage == ST_QUAR)
            return;
        stage       = ST_BEGIN;
        status      = RS_OK;
        retry_at_ms = now_ms;
    endfunction

    function void fail_at(logic [31:0] now_ms, logic [2:0] reason);
        if (stage == ST_QUAR)
            return;
        if (stage != ST_FAILED)
            failed_at = stage;
        stage  = ST_FAILED;
        status = reason;
        if (failures != COUNT_MAX)
            failures = failures + 16'd1;
        // pick the backoff from the updated count
        if (failures <= {8'd0, fast_limit})
            retry_at_ms = now_ms + {16'd0, fast_interval_ms};
        else
            retry_at_ms = now_ms + slow_interval_ms;
    endfunction

    function void note_event(event_t ev);
        logic [31:0] waited;
        report_t     want;
        case (ev.mode)
            MODE_TICK:
            begin
                if (stage == ST_FAILED || stage == ST_IDLE)
                begin
                    // wrapped signed compare against the retry time
                    waited = ev.now_ms - retry_at_ms;
                    if (!waited[31])
                        arm_at(ev.now_ms);
                end
                else if (stage >= ST_BEGIN && stage <= ST_AUTOPVT)
                begin
                    if (!ev.bus_ready)
                        fail_at(ev.now_ms, RS_BUS);
                    else
                    begin
                        case (stage)
                            ST_BEGIN:
                                if (!ev.buffer_ready || !ev.exchange_ok)
                                    fail_at(ev.now_ms, RS_INIT);
                                else
                                    stage = skip_output ? ST_DYNMODEL : ST_OUTPUT;
                            ST_OUTPUT:
                                if (!ev.exchange_ok) fail_at(ev.now_ms, RS_CONFIG);
                                else stage = ST_DYNMODEL;
                            ST_DYNMODEL:
                                if (!ev.exchange_ok) fail_at(ev.now_ms, RS_CONFIG);
                                else stage = ST_NAVFREQ;
                            ST_NAVFREQ:
                                if (!ev.exchange_ok) fail_at(ev.now_ms, RS_RATE);
                                else stage = ST_NAVRATE;
                            ST_NAVRATE:
                                if (!ev.exchange_ok) fail_at(ev.now_ms, RS_CONFIG);
                                else stage = ST_AUTOPVT;
                            default:
                                if (!ev.exchange_ok)
                                    fail_at(ev.now_ms, RS_CONFIG);
                                else
                                begin
                                    stage  = ST_DONE;
                                    status = RS_OK;
                                end
                        endcase
                    end
                end
            end
            MODE_ARM:     arm_at(ev.now_ms);
            MODE_FAIL:    fail_at(ev.now_ms, ev.fail_reason > RS_BUS ? RS_BUS : ev.fail_reason);
            MODE_CONFIRM: failures = '0;
            MODE_QUAR:
            begin
                stage     = ST_QUAR;
                failed_at = ST_BEGIN;
                status    = RS_BUS;
            end
            default: ;
        endcase
        want.stage_now     = stage;
        want.failed_stage  = failed_at;
        want.last_status   = status;
        want.failure_count = failures;
        expected_reports.push_back(want);
    endfunction

    function void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function void check_report(logic [31:0] word);
        report_t got;
        report_t want;
        got = word[26:0];
        if (expected_reports.size() == 0)
        begin
            note_mismatch($sformatf("report %h arrived with no event pending", word));
            return;
        end
        want = expected_reports.pop_front();
        reports_checked++;
        if (got.stage_now !== want.stage_now || got.failed_stage !== want.failed_stage ||
            got.last_status !== want.last_status ||
            got.failure_count !== want.failure_count || word[31:27] !== 5'd0)
            note_mismatch($sformatf(
                {"report %0d expected stage %0d failed %0d status %0d count %0d, ",
                 "got %0d %0d %0d %0d pad %h"},
                reports_checked, want.stage_now, want.failed_stage, want.last_status,
                want.failure_count, got.stage_now, got.failed_stage, got.last_status,
                got.failure_count, word[31:27]));
    endfunction

    function int pending();
        return expected_reports.size();
    endfunction
endclass

module tb;
    localparam int QUIET_LIMIT = 1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = MODE_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_FAST_LIMIT;
    logic [31:0] cfg_data = '0;

    bringup_scoreboard sb = new();

    bit          idling = 1'b0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int          events_sent = 0;
    logic [31:0] clock_ms = 32'd1000;

    staged_bringup_retry_sequencer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // monitor all three channels and watch for a stalled run
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
        if (s_axis_tvalid && s_axis_tready)
        begin
            sb.note_event(event_t'({s_axis_tdata[37:0], s_axis_tuser}));
            events_sent++;
        end
        if (m_axis_tvalid && m_axis_tready)
            sb.check_report(m_axis_tdata);

        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: nothing accepted for %0d cycles, %0d reports outstanding",
                         QUIET_LIMIT, sb.pending());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // report-side backpressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_event(input logic [2:0] mode, input logic [31:0] now_ms,
                              input logic bus_rdy, input logic buf_rdy,
                              input logic xchg_ok, input logic [2:0] reason);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b00, reason, xchg_ok, buf_rdy, bus_rdy, now_ms};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // drop valid and wait until every report is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] limit, input logic [15:0] fast_ms,
                                input logic [31:0] slow_ms, input logic skip);
        logic [31:0] vals[4];
        vals[REG_FAST_LIMIT]    = {24'd0, limit};
        vals[REG_FAST_INTERVAL] = {16'd0, fast_ms};
        vals[REG_SLOW_INTERVAL] = slow_ms;
        vals[REG_SKIP_OUTPUT]   = {31'd0, skip};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly small steps so backoffs expire gradually, with some jumps across the wrap
    function automatic void advance_clock();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            clock_ms = clock_ms + $urandom_range(0, 20);
        else if (pick < 16)
            clock_ms = clock_ms + $urandom_range(0, 300);
        else if (pick < 19)
            clock_ms = clock_ms + $urandom_range(300, 6000);
        else
            clock_ms = $urandom;
    endfunction

    task automatic random_events(input int count, input bit allow_idle);
        int         pick;
        logic [2:0] mode;
        for (int n = 0; n < count; n++)
        begin
            if (n % 30 == 0)
                idling = allow_idle && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 72)
                mode = MODE_TICK;
            else if (pick < 80)
                mode = MODE_ARM;
            else if (pick < 87)
                mode = MODE_FAIL;
            else if (pick < 93)
                mode = MODE_CONFIRM;
            else
                mode = MODE_QUAR + 3'($urandom_range(1, 3));
            advance_clock();
            send_event(mode, clock_ms, $urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0,
                       $urandom_range(0, 11) != 0, 3'($urandom_range(0, 7)));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the stages once with reset settings, then hit each failure kind
        idling = 1'b1;
        send_event(MODE_TICK, 32'h8000_0000, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_TICK, 32'd0, 1'b1, 1'b1, 1'b1, RS_OK);
        repeat (6) send_event(MODE_TICK, 32'd0, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_TICK, 32'd10, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_ARM, 32'd1000, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_TICK, 32'd1001, 1'b0, 1'b1, 1'b1, RS_OK);
        send_event(MODE_TICK, 32'd1250, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_FAIL, 32'd1250, 1'b1, 1'b1, 1'b1, 3'd7);
        send_event(MODE_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_TICK, 32'd1500, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_TICK, 32'd1501, 1'b1, 1'b0, 1'b1, RS_OK);
        send_event(MODE_ARM, 32'd2000, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_TICK, 32'd2001, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_TICK, 32'd2002, 1'b1, 1'b1, 1'b0, RS_OK);
        send_event(MODE_ARM, 32'd3000, 1'b1, 1'b1, 1'b1, RS_OK);
        repeat (3) send_event(MODE_TICK, 32'd3001, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_TICK, 32'd3002, 1'b1, 1'b1, 1'b0, RS_OK);
        send_event(MODE_QUAR + 3'd1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 3'd7);
        send_event(MODE_CONFIRM, 32'd3003, 1'b1, 1'b1, 1'b1, RS_OK);

        drain();
        program_regs(8'd0, 16'd0, 32'hFFFF_FFFF, 1'b1);
        random_events(225, 1'b1);

        drain();
        program_regs(8'd255, 16'hFFFF, 32'd0, 1'b0);
        random_events(250, 1'b1);

        drain();
        program_regs(8'd3, 16'd100, 32'd2000, 1'b1);
        random_events(225, 1'b1);

        drain();
        program_regs(8'd5, 16'd250, 32'd5000, 1'b0);
        random_events(200, 1'b0);

        // quarantine is terminal, so it comes last
        idling = 1'b0;
        send_event(MODE_QUAR, clock_ms, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_ARM, clock_ms, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_FAIL, clock_ms, 1'b1, 1'b1, 1'b1, RS_CONFIG);
        send_event(MODE_TICK, clock_ms + 32'd100000, 1'b0, 1'b0, 1'b0, RS_OK);
        send_event(MODE_CONFIRM, clock_ms, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_QUAR + 3'd2, clock_ms, 1'b1, 1'b1, 1'b1, RS_OK);
        send_event(MODE_QUAR, clock_ms, 1'b1, 1'b1, 1'b1, RS_OK);
        drain();

        if (sb.pending() != 0)
            sb.note_mismatch($sformatf("%0d reports never arrived", sb.pending()));
        $display("Covered %0d events: directed stage walk, four register settings, random",
                 events_sent);
        $display("ticks and failures with wrapped times, and quarantine; %0d reports compared, %0d mismatching.",
                 sb.reports_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
